// File: sv/ptw_pkg.sv
package ptw_pkg;

    localparam int DEFAULT_MEMORY_WORDS = 4096;
    localparam int QUEUE_DEPTH = 2;

    localparam int ROOT_W = 52;
    localparam int VA_W = 48;
    localparam int SLOT_W = 49;
    localparam int WORD_W = 64;
    localparam int INDEX_W = 12;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_WRITE = 1;
    localparam int BIT_USER = 2;
    localparam int BIT_LARGE = 7;
    localparam int BIT_NX = 63;

    localparam logic [1:0] LEAF_LEVEL = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_UNMAP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VA_W-1:0]    va;
        logic               need_user;
        logic               need_write;
        logic               need_nx;
        logic               ok;
        logic [WORD_W-1:0]  word_data;
    } entry_t;

endpackage

// File: sv/ptw_ram.sv
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/ptw_fifo.sv
module ptw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;

    assign full = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("Queue read while empty.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a push.");

endmodule

// File: sv/ptw_front.sv
module ptw_front #(
    parameter int MEMORY_WORDS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_enable,
    input  logic [ptw_pkg::ROOT_W-1:0]   cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [63:0]                  virt_addr,
    input  logic                         need_user,
    input  logic                         need_write,
    input  logic                         need_nx,
    input  logic [ptw_pkg::INDEX_W-1:0]  word_index,
    input  logic [ptw_pkg::WORD_W-1:0]   word_data,
    input  logic                         q_full,
    output logic                         q_push,
    output ptw_pkg::entry_t              q_entry,
    output logic [$clog2(MEMORY_WORDS)-1:0] q_addr
);

    import ptw_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam logic [SLOT_W-1:0] LIMIT = SLOT_W'(MEMORY_WORDS);

    logic [ROOT_W-1:0] root_reg;
    logic              root_ok;
    logic              canonical;
    logic [SLOT_W-1:0] root_slot;
    logic [SLOT_W-1:0] word_slot;
    op_t               op_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            root_reg <= cfg_write_data;
        end
    end

    // An aligned table base makes the slot a plain concatenation of frame and index.
    assign root_ok = (root_reg != '0) && (root_reg[11:0] == '0);
    assign canonical = (virt_addr[63:48] == '0) || (virt_addr[63:48] == '1);
    assign root_slot = {root_reg[ROOT_W-1:12], virt_addr[47:39]};
    assign word_slot = SLOT_W'(word_index);
    assign op_code = op_t'(op);

    assign in_ready = !q_full;
    assign q_push = in_valid && !q_full;

    always_comb
    begin
        q_entry.op = op_code;
        q_entry.va = virt_addr[VA_W-1:0];
        q_entry.need_user = need_user;
        q_entry.need_write = need_write;
        q_entry.need_nx = need_nx;
        q_entry.word_data = word_data;
        unique case (op_code)
            OP_WRITE, OP_READ:
            begin
                q_entry.ok = (word_slot < LIMIT);
                q_addr = AW'(word_index);
            end
            OP_LOOKUP, OP_UNMAP:
            begin
                q_entry.ok = root_ok && canonical && (root_slot < LIMIT);
                q_addr = root_slot[AW-1:0];
            end
            default:
            begin
                q_entry.ok = 1'b0;
                q_addr = '0;
            end
        endcase
    end

endmodule

// File: sv/ptw_back.sv
module ptw_back #(
    parameter int MEMORY_WORDS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  ptw_pkg::entry_t                 q_entry,
    input  logic [$clog2(MEMORY_WORDS)-1:0] q_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptw_pkg::ROOT_W-1:0]      phys_addr,
    output logic                            found,
    output logic [ptw_pkg::WORD_W-1:0]      read_data
);

    import ptw_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam logic [SLOT_W-1:0] LIMIT = SLOT_W'(MEMORY_WORDS);

    typedef enum logic [2:0] {
        ST_IDLE      = 3'b001,
        ST_WAIT_READ = 3'b010,
        ST_WALK      = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [1:0]        level_reg;
    logic [1:0]        level_next;
    entry_t            entry_reg;
    entry_t            entry_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ROOT_W-1:0] phys_addr_reg;
    logic              found_reg;
    logic [WORD_W-1:0] read_data_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              out_free;
    logic              res_load;
    logic [ROOT_W-1:0] res_pa;
    logic              res_found;
    logic [WORD_W-1:0] res_rdata;
    logic [8:0]        next_idx;
    logic [SLOT_W-1:0] next_slot;
    logic              leaf_ok;

    ptw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEMORY_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (level_reg)
            2'd0:    next_idx = entry_reg.va[38:30];
            2'd1:    next_idx = entry_reg.va[29:21];
            default: next_idx = entry_reg.va[20:12];
        endcase
    end

    assign next_slot = {ram_rdata[51:12], next_idx};
    assign leaf_ok = ram_rdata[BIT_PRESENT]
        && (!entry_reg.need_user || ram_rdata[BIT_USER])
        && (!entry_reg.need_write || ram_rdata[BIT_WRITE])
        && (!entry_reg.need_nx || ram_rdata[BIT_NX]);

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        entry_next = entry_reg;
        addr_next = addr_reg;
        q_pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_re = 1'b0;
        ram_raddr = q_addr;
        res_load = 1'b0;
        res_pa = '0;
        res_found = 1'b0;
        res_rdata = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    entry_next = q_entry;
                    addr_next = q_addr;
                    level_next = '0;
                    unique case (q_entry.op)
                        OP_WRITE:
                        begin
                            ram_we = q_entry.ok;
                            ram_waddr = q_addr;
                            ram_wdata = q_entry.word_data;
                            res_load = 1'b1;
                        end
                        OP_READ:
                        begin
                            if (q_entry.ok)
                            begin
                                ram_re = 1'b1;
                                state_next = ST_WAIT_READ;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        OP_LOOKUP, OP_UNMAP:
                        begin
                            if (q_entry.ok)
                            begin
                                ram_re = 1'b1;
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_WAIT_READ:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_rdata = ram_rdata;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (level_reg != LEAF_LEVEL)
                begin
                    if (!ram_rdata[BIT_PRESENT] || ram_rdata[BIT_LARGE]
                        || (next_slot >= LIMIT))
                    begin
                        if (out_free)
                        begin
                            res_load = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        ram_re = 1'b1;
                        ram_raddr = next_slot[AW-1:0];
                        addr_next = next_slot[AW-1:0];
                        level_next = level_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    res_load = 1'b1;
                    state_next = ST_IDLE;
                    if (entry_reg.op == OP_UNMAP)
                    begin
                        ram_we = 1'b1;
                        res_pa = {ram_rdata[51:12], 12'h000};
                        res_found = 1'b1;
                    end
                    else if (leaf_ok)
                    begin
                        res_pa = {ram_rdata[51:12], entry_reg.va[11:0]};
                        res_found = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        addr_reg <= addr_next;
        if (res_load)
        begin
            phys_addr_reg <= res_pa;
            found_reg <= res_found;
            read_data_reg <= res_rdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign phys_addr = phys_addr_reg;
    assign found = found_reg;
    assign read_data = read_data_reg;

    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.ok && (q_entry.op == OP_LOOKUP || q_entry.op == OP_UNMAP))
        |=> (state_reg == ST_WALK) && (level_reg == 2'd0))
        else $error("A valid walk did not start at the top level.");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("Memory written and read in the same cycle.");

    a_read_follow: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == ST_WAIT_READ) || (state_reg == ST_WALK))
        else $error("Memory read issued with nobody waiting for it.");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (read_data_reg == '0))
        else $error("A walk result carries read data.");

endmodule

// File: sv/four_level_page_table_walker_unit.sv
// Page table walker over a local table memory of MEMORY_WORDS 64-bit words.
// Items enter on in_valid/in_ready and results leave on out_valid/out_ready,
// one result for each item and in the same order. An item writes or reads a
// memory word, looks up a virtual address, or unmaps one.
// The user must write the root table address through cfg_write_enable and
// cfg_write_data only while the block is idle; the block does not enforce it.
// An accepted item waits in a two-entry queue, so in_ready stays high while
// the back end works or the receiver stalls, until the queue fills.
// The back end carries out one item at a time; a walk reads its four levels
// one after another through the single memory port.
// An unmap clears its leaf word in the cycle its result is registered.
// A stalled receiver holds the result register, and the back end waits.
// Reset clears the root register, the queue and the output valid; the table
// memory is not cleared and must be written before it is walked.
module four_level_page_table_walker_unit #(
    parameter int MEMORY_WORDS = ptw_pkg::DEFAULT_MEMORY_WORDS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_enable,
    input  logic [ptw_pkg::ROOT_W-1:0]   cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [63:0]                  virt_addr,
    input  logic                         need_user,
    input  logic                         need_write,
    input  logic                         need_nx,
    input  logic [ptw_pkg::INDEX_W-1:0]  word_index,
    input  logic [ptw_pkg::WORD_W-1:0]   word_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ptw_pkg::ROOT_W-1:0]   phys_addr,
    output logic                         found,
    output logic [ptw_pkg::WORD_W-1:0]   read_data
);

    import ptw_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam int QW = $bits(entry_t) + AW;

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    entry_t        push_entry;
    logic [AW-1:0] push_addr;
    logic [QW-1:0] pop_data;
    entry_t        pop_entry;
    logic [AW-1:0] pop_addr;

    ptw_front #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .virt_addr        (virt_addr),
        .need_user        (need_user),
        .need_write       (need_write),
        .need_nx          (need_nx),
        .word_index       (word_index),
        .word_data        (word_data),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_entry          (push_entry),
        .q_addr           (push_addr)
    );

    ptw_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_entry, push_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign pop_entry = entry_t'(pop_data[QW-1:AW]);
    assign pop_addr = pop_data[AW-1:0];

    ptw_back #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_entry          (pop_entry),
        .q_addr           (pop_addr),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .phys_addr        (phys_addr),
        .found            (found),
        .read_data        (read_data)
    );

endmodule

// File: verif/four_level_page_table_walker_unit_test.sv
`timescale 1ns / 100ps

module four_level_page_table_walker_unit_test;

    import ptw_pkg::*;

    localparam int MEM_WORDS = DEFAULT_MEMORY_WORDS;
    localparam logic [63:0] FRAME_BITS = 64'h000f_ffff_ffff_f000;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_TARGET = 1400;
    localparam int STEADY_ITEMS = 150;

    typedef enum int {WALK_FAIL, WALK_LEAF, WALK_UNSEEN} walk_t;

    typedef struct packed {
        logic [ROOT_W-1:0] pa;
        logic              found;
        logic [63:0]       rd;
    } translation_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_enable;
    logic [ROOT_W-1:0] cfg_write_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [63:0]       virt_addr;
    logic              need_user;
    logic              need_write;
    logic              need_nx;
    logic [11:0]       word_index;
    logic [63:0]       word_data;
    logic              out_valid;
    logic              out_ready;
    logic [ROOT_W-1:0] phys_addr;
    logic              found;
    logic [63:0]       read_data;

    logic [63:0]       table_mem [0:MEM_WORDS-1];
    bit                written [0:MEM_WORDS-1];
    logic [11:0]       written_list [$];
    logic [ROOT_W-1:0] root_address;
    translation_t      awaited [$];

    bit idling = 1'b1;
    int errors = 0;
    int items_sent = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int translated = 0;
    int root_settings = 0;
    int quiet_cycles = 0;

    four_level_page_table_walker_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .virt_addr(virt_addr),
        .need_user(need_user),
        .need_write(need_write),
        .need_nx(need_nx),
        .word_index(word_index),
        .word_data(word_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .phys_addr(phys_addr),
        .found(found),
        .read_data(read_data)
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] make_va(input logic [15:0] top, input logic [8:0] i4,
                                            input logic [8:0] i3, input logic [8:0] i2,
                                            input logic [8:0] i1, input logic [11:0] offset);
        return {top, i4, i3, i2, i1, offset};
    endfunction

    function automatic logic [63:0] word_of(input logic [63:0] base, input logic [63:0] va,
                                            input int lvl);
        return (base >> 3) + ((va >> (39 - 9 * lvl)) & 64'h1ff);
    endfunction

    // Follows the walk through the tables as they now stand. A walk that would
    // read a word never written stops and names that word.
    function automatic walk_t walk_tables(input logic [63:0] va, output logic [11:0] leaf,
                                          output logic [11:0] unseen);
        logic [63:0] base;
        logic [63:0] w;
        logic [63:0] e;
        leaf = '0;
        unseen = '0;
        base = {12'd0, root_address};
        if (root_address == 0 || root_address[11:0] != 0 ||
            !(va[63:48] == 16'h0000 || va[63:48] == 16'hffff))
            return WALK_FAIL;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            w = word_of(base, va, lvl);
            if (w >= MEM_WORDS)
                return WALK_FAIL;
            if (!written[w[11:0]])
            begin
                unseen = w[11:0];
                return WALK_UNSEEN;
            end
            if (lvl == 3)
            begin
                leaf = w[11:0];
                return WALK_LEAF;
            end
            e = table_mem[w[11:0]];
            if (!e[BIT_PRESENT] || e[BIT_LARGE])
                return WALK_FAIL;
            base = e & FRAME_BITS;
        end
        return WALK_FAIL;
    endfunction

    function automatic translation_t predict_translation(input op_t kind,
                                                         input logic [63:0] va,
                                                         input logic [2:0] needs,
                                                         input logic [11:0] wi,
                                                         input logic [63:0] wd);
        translation_t res;
        logic [11:0] leaf;
        logic [11:0] unseen;
        logic [63:0] e;
        res = '0;
        case (kind)
            OP_WRITE:
            begin
                if (!written[wi])
                    written_list.push_back(wi);
                written[wi] = 1'b1;
                table_mem[wi] = wd;
            end
            OP_READ:
                res.rd = table_mem[wi];
            OP_LOOKUP:
            begin
                if (walk_tables(va, leaf, unseen) == WALK_LEAF)
                begin
                    e = table_mem[leaf];
                    if (e[BIT_PRESENT] && (!needs[2] || e[BIT_USER]) &&
                        (!needs[1] || e[BIT_WRITE]) && (!needs[0] || e[BIT_NX]))
                    begin
                        res.pa = {e[51:12], va[11:0]};
                        res.found = 1'b1;
                    end
                end
            end
            OP_UNMAP:
            begin
                if (walk_tables(va, leaf, unseen) == WALK_LEAF)
                begin
                    res.pa = {table_mem[leaf][51:12], 12'h000};
                    res.found = 1'b1;
                    table_mem[leaf] = 64'd0;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] random_entry();
        logic [63:0] e;
        e = rand64();
        if ($urandom_range(0, 9) != 0)
            e[51:12] = 40'($urandom_range(0, 7));
        e[BIT_PRESENT] = ($urandom_range(0, 7) != 0);
        e[BIT_LARGE] = ($urandom_range(0, 9) == 0);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("Mismatch at %0t: %s is %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_item(input op_t kind, input logic [63:0] va, input logic [2:0] needs,
                             input logic [11:0] wi, input logic [63:0] wd);
        translation_t res;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        virt_addr <= va;
        {need_user, need_write, need_nx} <= needs;
        word_index <= wi;
        word_data <= wd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = predict_translation(kind, va, needs, wi, wd);
        awaited.push_back(res);
        items_sent++;
        op_count[kind]++;
        if (kind == OP_LOOKUP && res.found)
            translated++;
    endtask

    task automatic write_word(input logic [11:0] wi, input logic [63:0] wd);
        send_item(OP_WRITE, rand64(), 3'($urandom), wi, wd);
    endtask

    task automatic read_word(input logic [11:0] wi);
        send_item(OP_READ, rand64(), 3'($urandom), wi, rand64());
    endtask

    // Every word the walk will read is written first, so no walk reads an
    // uninitialized table entry.
    task automatic walk_item(input op_t kind, input logic [63:0] va, input logic [2:0] needs);
        logic [11:0] leaf;
        logic [11:0] unseen;
        while (walk_tables(va, leaf, unseen) == WALK_UNSEEN)
            write_word(unseen, random_entry());
        send_item(kind, va, needs, 12'($urandom), rand64());
    endtask

    task automatic map_page(input logic [63:0] va, input logic [63:0] leaf,
                            input bit fixed_pages);
        logic [63:0] base;
        logic [63:0] e;
        int pg;
        base = {12'd0, root_address};
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            pg = fixed_pages ? lvl + 2 : $urandom_range(0, 7);
            e = fixed_pages ? 64'h7 : rand64();
            e[51:12] = 40'(pg);
            e[BIT_PRESENT] = 1'b1;
            e[BIT_LARGE] = 1'b0;
            write_word(12'(word_of(base, va, lvl)), e);
            base = pg * 64'd4096;
        end
        write_word(12'(word_of(base, va, 3)), leaf);
    endtask

    task automatic set_root(input logic [ROOT_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        root_address = value;
        root_settings++;
    endtask

    task automatic map_and_walk();
        logic [63:0] va;
        logic [63:0] leaf;
        op_t kind;
        va = rand64();
        va[63:48] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        leaf = rand64();
        leaf[BIT_PRESENT] = ($urandom_range(0, 6) != 0);
        if (root_address != 0 && root_address[11:0] == 0 && root_address < 52'h8000)
            map_page(va, leaf, 1'b0);
        repeat ($urandom_range(1, 3))
        begin
            va[11:0] = 12'($urandom);
            if ($urandom_range(0, 3) == 0)
                kind = OP_UNMAP;
            else
                kind = OP_LOOKUP;
            walk_item(kind, va, 3'($urandom));
        end
    endtask

    task automatic random_noise();
        logic [63:0] va;
        op_t kind;
        va = rand64();
        if ($urandom_range(0, 1) == 0)
            kind = OP_UNMAP;
        else
            kind = OP_LOOKUP;
        case ($urandom_range(0, 9))
            0, 1:
                write_word(12'($urandom), rand64());
            2:
                write_word(12'($urandom), random_entry());
            3, 4, 5:
                read_word(written_list[$urandom_range(0, written_list.size() - 1)]);
            6, 7:
            begin
                va[63:48] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                walk_item(kind, va, 3'($urandom));
            end
            default:
                walk_item(kind, va, 3'($urandom));
        endcase
    endtask

    function automatic logic [ROOT_W-1:0] pick_root();
        logic [ROOT_W-1:0] r;
        r = ROOT_W'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0:
                r = '0;
            1:
                r = ROOT_W'({$urandom_range(1, 7), 12'h000}) | ROOT_W'($urandom_range(1, 4095));
            2:
                r[11:0] = $urandom_range(0, 1) ? 12'h000 : r[11:0];
            default:
                r = ROOT_W'({$urandom_range(1, 7), 12'h000});
        endcase
        return r;
    endfunction

    task automatic test_memory_words();
        write_word(12'd0, 64'd0);
        write_word(12'd4095, 64'hffff_ffff_ffff_ffff);
        read_word(12'd0);
        read_word(12'd4095);
    endtask

    task automatic test_directed_walks();
        logic [63:0] va;
        logic [11:0] leaf_word;
        va = make_va(16'h0000, 9'h1ff, 9'h000, 9'h155, 9'h0aa, 12'hfff);
        leaf_word = 12'd2048 + 12'h0aa;
        set_root(52'h1000);
        map_page(va, 64'h800f_ffff_ffff_f007, 1'b1);
        walk_item(OP_LOOKUP, va, 3'b111);
        walk_item(OP_LOOKUP, {16'hffff, va[47:12], 12'h000}, 3'b000);
        walk_item(OP_LOOKUP, {16'h8000, va[47:0]}, 3'b000);
        walk_item(OP_UNMAP, va, 3'b111);
        walk_item(OP_LOOKUP, va, 3'b000);
        // An unmap of a leaf that is not present still reports success.
        walk_item(OP_UNMAP, va, 3'b000);
        write_word(leaf_word, 64'h3);
        walk_item(OP_LOOKUP, va, 3'b100);
        // The large page bit has no effect at the last level.
        write_word(leaf_word, 64'h0000_0000_1234_5085);
        walk_item(OP_LOOKUP, va, 3'b100);
        write_word(12'(word_of(64'h3000, va, 2)), 64'h4081);
        walk_item(OP_LOOKUP, va, 3'b000);
        // A table that lies past the end of the memory fails the walk.
        write_word(12'(word_of(64'h1000, va, 0)), 64'h8003);
        walk_item(OP_LOOKUP, va, 3'b000);
        set_root('0);
        walk_item(OP_LOOKUP, va, 3'b000);
        set_root(52'h1008);
        walk_item(OP_UNMAP, va, 3'b000);
        set_root(52'hf_ffff_ffff_f000);
        walk_item(OP_LOOKUP, va, 3'b000);
        set_root(52'hf_ffff_ffff_ffff);
        walk_item(OP_UNMAP, va, 3'b000);
    endtask

    task automatic test_random_walks();
        int phase_end;
        while (items_sent < RANDOM_TARGET)
        begin
            set_root(pick_root());
            phase_end = items_sent + $urandom_range(120, 200);
            while (items_sent < phase_end && items_sent < RANDOM_TARGET)
            begin
                if ($urandom_range(0, 9) < 6)
                    map_and_walk();
                else
                    random_noise();
            end
        end
    endtask

    task automatic test_steady_stream();
        int stream_end;
        set_root(ROOT_W'({$urandom_range(1, 7), 12'h000}));
        idling = 1'b0;
        stream_end = items_sent + STEADY_ITEMS;
        while (items_sent < stream_end)
        begin
            if ($urandom_range(0, 9) < 7)
                map_and_walk();
            else
                random_noise();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_write_data <= '0;
        in_valid <= 1'b0;
        op <= OP_WRITE;
        virt_addr <= '0;
        need_user <= 1'b0;
        need_write <= 1'b0;
        need_nx <= 1'b0;
        word_index <= '0;
        word_data <= '0;
        root_address = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_memory_words();
        test_directed_walks();
        test_random_walks();
        test_steady_stream();
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        $display("Sent %0d items: %0d writes, %0d reads, %0d lookups (%0d translated), %0d unmaps.",
                 items_sent, op_count[OP_WRITE], op_count[OP_READ], op_count[OP_LOOKUP],
                 translated, op_count[OP_UNMAP]);
        $display("Walks ran under %0d root table settings; %0d mismatches seen.",
                 root_settings, errors);
        if (errors == 0)
            $display("four_level_page_table_walker_unit_test OK");
        else
            $display("four_level_page_table_walker_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        translation_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited.size() == 0)
                report_mismatch("unexpected item", {12'd0, phys_addr}, '0);
            else
            begin
                want = awaited.pop_front();
                if (phys_addr !== want.pa)
                    report_mismatch("phys_addr", {12'd0, phys_addr}, {12'd0, want.pa});
                if (found !== want.found)
                    report_mismatch("found", {63'd0, found}, {63'd0, want.found});
                if (read_data !== want.rd)
                    report_mismatch("read_data", read_data, want.rd);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timed out after %0d cycles without a handshake.", quiet_cycles);
            $display("four_level_page_table_walker_unit_test NOT OK");
            $finish;
        end
    end

endmodule

// File: filelist.f
sv/ptw_pkg.sv
sv/ptw_ram.sv
sv/ptw_fifo.sv
sv/ptw_front.sv
sv/ptw_back.sv
sv/four_level_page_table_walker_unit.sv
verif/four_level_page_table_walker_unit_test.sv
